@@ rtl/foccl_pkg.sv @@
`timescale 1ns / 1ps
package foccl_pkg;

  // Input beat: one sample per PWM period
  typedef struct packed {
    logic signed [15:0] phase_a_current;
    logic signed [15:0] phase_b_current;
    logic        [15:0] rotor_angle;
    logic signed [15:0] d_current_target;
    logic signed [15:0] q_current_target;
  } in_beat_t;

  // Output beat
  typedef struct packed {
    logic        [15:0] compare_a;
    logic        [15:0] compare_b;
    logic        [15:0] compare_c;
    logic signed [15:0] d_current_measured;
    logic signed [15:0] q_current_measured;
    logic signed [15:0] d_voltage;
    logic signed [15:0] q_voltage;
  } out_beat_t;

  // Configuration registers
  typedef struct packed {
    logic [15:0] d_prop_gain;
    logic [15:0] d_integral_gain;
    logic [15:0] d_deriv_gain;
    logic [15:0] q_prop_gain;
    logic [15:0] q_integral_gain;
    logic [15:0] q_deriv_gain;
    logic [30:0] accumulator_limit;
    logic [14:0] voltage_limit;
  } cfg_t;

  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_D_PROP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_D_INTEG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D_DERIV = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Q_PROP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Q_INTEG = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Q_DERIV = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_LIM = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_V_LIM   = 3'd7;

  // Multiplier A operand selects
  localparam logic [3:0] A_IAB2    = 4'd0;
  localparam logic [3:0] A_IA      = 4'd1;
  localparam logic [3:0] A_BETA    = 4'd2;
  localparam logic [3:0] A_LAST_D  = 4'd3;
  localparam logic [3:0] A_SUM_D   = 4'd4;
  localparam logic [3:0] A_DIFF_D  = 4'd5;
  localparam logic [3:0] A_LAST_Q  = 4'd6;
  localparam logic [3:0] A_SUM_Q   = 4'd7;
  localparam logic [3:0] A_DIFF_Q  = 4'd8;
  localparam logic [3:0] A_VD      = 4'd9;
  localparam logic [3:0] A_VQ      = 4'd10;
  localparam logic [3:0] A_VALPHA  = 4'd11;
  localparam logic [3:0] A_VBETA   = 4'd12;
  localparam logic [3:0] A_DUTY_A  = 4'd13;
  localparam logic [3:0] A_DUTY_B  = 4'd14;
  localparam logic [3:0] A_DUTY_C  = 4'd15;

  // Multiplier B operand selects
  localparam logic [3:0] B_INV_SQ3 = 4'd0;
  localparam logic [3:0] B_COS     = 4'd1;
  localparam logic [3:0] B_SIN     = 4'd2;
  localparam logic [3:0] B_KP_D    = 4'd3;
  localparam logic [3:0] B_KI_D    = 4'd4;
  localparam logic [3:0] B_KD_D    = 4'd5;
  localparam logic [3:0] B_KP_Q    = 4'd6;
  localparam logic [3:0] B_KI_Q    = 4'd7;
  localparam logic [3:0] B_KD_Q    = 4'd8;
  localparam logic [3:0] B_HALF    = 4'd9;
  localparam logic [3:0] B_HALF_SQ3 = 4'd10;
  localparam logic [3:0] B_PERIOD  = 4'd11;

  // Writeback targets, taken from the accumulator or, for PREP, from the PID front end
  localparam logic [3:0] W_NONE    = 4'd0;
  localparam logic [3:0] W_BETA    = 4'd1;
  localparam logic [3:0] W_ID      = 4'd2;
  localparam logic [3:0] W_IQ      = 4'd3;
  localparam logic [3:0] W_PREP_D  = 4'd4;
  localparam logic [3:0] W_PREP_Q  = 4'd5;
  localparam logic [3:0] W_VD      = 4'd6;
  localparam logic [3:0] W_VQ      = 4'd7;
  localparam logic [3:0] W_VALPHA  = 4'd8;
  localparam logic [3:0] W_VBETA   = 4'd9;
  localparam logic [3:0] W_VB      = 4'd10;
  localparam logic [3:0] W_VC      = 4'd11;
  localparam logic [3:0] W_CMPA    = 4'd12;
  localparam logic [3:0] W_CMPB    = 4'd13;
  localparam logic [3:0] W_CMPC    = 4'd14;

  // Controller to datapath command
  typedef struct packed {
    logic       load_in;
    logic       load_out;
    logic       mac;
    logic       clr;
    logic       neg;
    logic       sh8;
    logic [3:0] a_sel;
    logic [3:0] b_sel;
    logic [3:0] wr;
  } cmd_t;

  // Fixed-point constants
  localparam logic signed [16:0] INV_SQRT3_Q15  = 17'sd18919;
  localparam logic signed [16:0] HALF_Q15       = 17'sd16384;
  localparam logic signed [16:0] HALF_SQRT3_Q15 = 17'sd28378;
  localparam logic signed [18:0] DUTY_MID       = 19'sd16384;
  localparam logic signed [18:0] DUTY_LOW       = 19'sd1638;
  localparam logic signed [18:0] DUTY_HIGH      = 19'sd31130;

  // Quarter-wave sine, round(32767*sin(k*pi/64))
  localparam logic [14:0] QUARTER_SINE [0:32] = '{
    15'd0,     15'd1608,  15'd3212,  15'd4808,  15'd6393,  15'd7962,  15'd9512,
    15'd11039, 15'd12539, 15'd14010, 15'd15446, 15'd16846, 15'd18204, 15'd19519,
    15'd20787, 15'd22005, 15'd23170, 15'd24279, 15'd25329, 15'd26319, 15'd27245,
    15'd28105, 15'd28898, 15'd29621, 15'd30273, 15'd30852, 15'd31356, 15'd31785,
    15'd32137, 15'd32412, 15'd32609, 15'd32728, 15'd32767
  };

endpackage

@@ rtl/foccl_regs.sv @@
`timescale 1ns / 1ps
module foccl_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [foccl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [foccl_pkg::CFG_DATA_W-1:0]    cfg_data,
  output foccl_pkg::cfg_t                     cfg
);
  import foccl_pkg::*;

  // Register file, each keeps its own width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.d_prop_gain       <= 16'd256;
      cfg.d_integral_gain   <= 16'd0;
      cfg.d_deriv_gain      <= 16'd0;
      cfg.q_prop_gain       <= 16'd256;
      cfg.q_integral_gain   <= 16'd0;
      cfg.q_deriv_gain      <= 16'd0;
      cfg.accumulator_limit <= 31'h7FFF_FFFF;
      cfg.voltage_limit     <= 15'd32767;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_D_PROP:  cfg.d_prop_gain       <= cfg_data[15:0];
        REG_D_INTEG: cfg.d_integral_gain   <= cfg_data[15:0];
        REG_D_DERIV: cfg.d_deriv_gain      <= cfg_data[15:0];
        REG_Q_PROP:  cfg.q_prop_gain       <= cfg_data[15:0];
        REG_Q_INTEG: cfg.q_integral_gain   <= cfg_data[15:0];
        REG_Q_DERIV: cfg.q_deriv_gain      <= cfg_data[15:0];
        REG_ACC_LIM: cfg.accumulator_limit <= cfg_data[30:0];
        REG_V_LIM:   cfg.voltage_limit     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/foccl_dp.sv @@
`timescale 1ns / 1ps
module foccl_dp #(
  parameter int PWM_PERIOD_COUNTS = 4096,
  parameter int SINE_TABLE_BITS   = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  foccl_pkg::cmd_t      cmd,
  input  foccl_pkg::cfg_t      cfg,
  input  foccl_pkg::in_beat_t  in_data,
  output foccl_pkg::out_beat_t out_data
);
  import foccl_pkg::*;

  localparam int QB = SINE_TABLE_BITS - 2;
  localparam logic [SINE_TABLE_BITS-1:0] QUARTER = {2'b01, {QB{1'b0}}};
  localparam logic signed [16:0] PERIOD = $signed(17'(PWM_PERIOD_COUNTS));

  // Interpolated quarter-wave lookup, position 0..QUARTER
  function automatic logic [15:0] quarter_lookup(input logic [QB:0] p);
    logic [15:0] f;
    logic [5:0]  i;
    logic [7:0]  fr;
    logic [14:0] lo;
    logic [14:0] hi;
    logic [19:0] t;
    f  = 16'(p) << (15 - SINE_TABLE_BITS);
    i  = f[13:8];
    fr = f[7:0];
    if (i >= 6'd32) begin
      return {1'b0, QUARTER_SINE[32]};
    end
    lo = QUARTER_SINE[i];
    hi = QUARTER_SINE[6'(i + 6'd1)];
    t  = 20'(hi - lo) * 20'(fr) + 20'd128;
    return 16'(lo) + 16'(t >> 8);
  endfunction

  function automatic logic signed [15:0] sine_at(input logic [SINE_TABLE_BITS-1:0] idx);
    logic [1:0]  quad;
    logic [QB:0] p;
    logic [15:0] m;
    quad = idx[SINE_TABLE_BITS-1 -: 2];
    p    = {1'b0, idx[QB-1:0]};
    if (quad[0]) begin
      p = QUARTER[QB:0] - p;
    end
    m = quarter_lookup(p);
    return quad[1] ? -$signed(m) : $signed(m);
  endfunction

  // duty = 0.5 + v, clamped to 0.05..0.95
  function automatic logic [14:0] duty_of(input logic signed [17:0] v);
    logic signed [18:0] t;
    t = 19'(v) + DUTY_MID;
    if (t < DUTY_LOW) begin
      t = DUTY_LOW;
    end else if (t > DUTY_HIGH) begin
      t = DUTY_HIGH;
    end
    return t[14:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [57:0] v);
    if (v > 58'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -58'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // Working registers
  logic signed [15:0] ia, ib, d_ref, q_ref, sn, cs;
  logic signed [15:0] beta, id, iq, vd, vq;
  logic signed [31:0] sum_d, sum_q;
  logic signed [16:0] last_d, last_q;
  logic signed [17:0] diff_d, diff_q;
  logic signed [17:0] valpha, vbeta, vb, vc;
  logic        [15:0] cmp_a, cmp_b, cmp_c;
  logic signed [48:0] prod;
  logic signed [57:0] acc;
  logic               mac_q, clr_q, neg_q, sh8_q;

  logic [SINE_TABLE_BITS-1:0] angle_idx;
  logic signed [31:0] a_op;
  logic signed [16:0] b_op;
  logic signed [57:0] term;
  logic signed [57:0] r15, r16, vlim;
  logic signed [16:0] err;
  logic signed [32:0] sum_new, alim;

  assign angle_idx = in_data.rotor_angle[15 -: SINE_TABLE_BITS];

  // Operand select
  always_comb begin
    case (cmd.a_sel)
      A_IAB2:   a_op = 32'(ia) + (32'(ib) <<< 1);
      A_IA:     a_op = 32'(ia);
      A_BETA:   a_op = 32'(beta);
      A_LAST_D: a_op = 32'(last_d);
      A_SUM_D:  a_op = sum_d;
      A_DIFF_D: a_op = 32'(diff_d);
      A_LAST_Q: a_op = 32'(last_q);
      A_SUM_Q:  a_op = sum_q;
      A_DIFF_Q: a_op = 32'(diff_q);
      A_VD:     a_op = 32'(vd);
      A_VQ:     a_op = 32'(vq);
      A_VALPHA: a_op = 32'(valpha);
      A_VBETA:  a_op = 32'(vbeta);
      A_DUTY_A: a_op = $signed({17'd0, duty_of(valpha)});
      A_DUTY_B: a_op = $signed({17'd0, duty_of(vb)});
      A_DUTY_C: a_op = $signed({17'd0, duty_of(vc)});
      default:  a_op = '0;
    endcase
    case (cmd.b_sel)
      B_INV_SQ3:  b_op = INV_SQRT3_Q15;
      B_COS:      b_op = 17'(cs);
      B_SIN:      b_op = 17'(sn);
      B_KP_D:     b_op = $signed({1'b0, cfg.d_prop_gain});
      B_KI_D:     b_op = $signed({1'b0, cfg.d_integral_gain});
      B_KD_D:     b_op = $signed({1'b0, cfg.d_deriv_gain});
      B_KP_Q:     b_op = $signed({1'b0, cfg.q_prop_gain});
      B_KI_Q:     b_op = $signed({1'b0, cfg.q_integral_gain});
      B_KD_Q:     b_op = $signed({1'b0, cfg.q_deriv_gain});
      B_HALF:     b_op = HALF_Q15;
      B_HALF_SQ3: b_op = HALF_SQRT3_Q15;
      B_PERIOD:   b_op = PERIOD;
      default:    b_op = '0;
    endcase
  end

  // Accumulator term, scaled and signed
  always_comb begin
    term = sh8_q ? (58'(prod) <<< 8) : 58'(prod);
    if (neg_q) begin
      term = -term;
    end
  end

  // Rounded views of the accumulator
  assign r15  = (acc + 58'sd16384) >>> 15;
  assign r16  = (acc + 58'sd32768) >>> 16;
  assign vlim = $signed({43'd0, cfg.voltage_limit});
  assign alim = $signed({2'b00, cfg.accumulator_limit});

  // PID front end: error and clamped sum for the loop being prepared
  always_comb begin
    if (cmd.wr == W_PREP_Q) begin
      err     = 17'(q_ref) - 17'(iq);
      sum_new = 33'(sum_q) + 33'(err);
    end else begin
      err     = 17'(d_ref) - 17'(id);
      sum_new = 33'(sum_d) + 33'(err);
    end
    if (sum_new > alim) begin
      sum_new = alim;
    end else if (sum_new < -alim) begin
      sum_new = -alim;
    end
  end

  // Shared multiplier and accumulator
  always_ff @(posedge clk) begin
    prod  <= 49'(a_op) * 49'(b_op);
    mac_q <= cmd.mac;
    clr_q <= cmd.clr;
    neg_q <= cmd.neg;
    sh8_q <= cmd.sh8;
    if (mac_q) begin
      acc <= (clr_q ? 58'sd0 : acc) + term;
    end
  end

  // Input capture and sine/cosine lookup
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ia    <= in_data.phase_a_current;
      ib    <= in_data.phase_b_current;
      d_ref <= in_data.d_current_target;
      q_ref <= in_data.q_current_target;
      sn    <= sine_at(angle_idx);
      cs    <= sine_at(angle_idx + QUARTER);
    end
  end

  // Writeback from the accumulator and the PID front end; loop state clears on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_d  <= '0;
      sum_q  <= '0;
      last_d <= '0;
      last_q <= '0;
    end else begin
      case (cmd.wr)
        W_BETA:   beta <= sat16(r15);
        W_ID:     id   <= sat16(r15);
        W_IQ:     iq   <= sat16(r15);
        W_PREP_D: begin
          sum_d  <= sum_new[31:0];
          diff_d <= 18'(err) - 18'(last_d);
          last_d <= err;
        end
        W_PREP_Q: begin
          sum_q  <= sum_new[31:0];
          diff_q <= 18'(err) - 18'(last_q);
          last_q <= err;
        end
        W_VD: begin
          if (r16 > vlim) begin
            vd <= vlim[15:0];
          end else if (r16 < -vlim) begin
            vd <= 16'(-vlim);
          end else begin
            vd <= r16[15:0];
          end
        end
        W_VQ: begin
          if (r16 > vlim) begin
            vq <= vlim[15:0];
          end else if (r16 < -vlim) begin
            vq <= 16'(-vlim);
          end else begin
            vq <= r16[15:0];
          end
        end
        W_VALPHA: valpha <= r15[17:0];
        W_VBETA:  vbeta  <= r15[17:0];
        W_VB:     vb     <= r15[17:0];
        W_VC:     vc     <= r15[17:0];
        W_CMPA:   cmp_a  <= acc[30:15];
        W_CMPB:   cmp_b  <= acc[30:15];
        W_CMPC:   cmp_c  <= acc[30:15];
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.compare_a          <= cmp_a;
      out_data.compare_b          <= cmp_b;
      out_data.compare_c          <= cmp_c;
      out_data.d_current_measured <= id;
      out_data.q_current_measured <= iq;
      out_data.d_voltage          <= vd;
      out_data.q_voltage          <= vq;
    end
  end

endmodule

@@ rtl/foccl_ctrl.sv @@
`timescale 1ns / 1ps
module foccl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output foccl_pkg::cmd_t cmd
);
  import foccl_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [4:0] LAST_STEP = 5'd31;

  logic [1:0] state;
  logic [4:0] step;

  function automatic cmd_t mul_op(input logic [3:0] a, input logic [3:0] b,
                                  input logic clr, input logic neg, input logic sh8);
    cmd_t c;
    c       = '0;
    c.mac   = 1'b1;
    c.clr   = clr;
    c.neg   = neg;
    c.sh8   = sh8;
    c.a_sel = a;
    c.b_sel = b;
    return c;
  endfunction

  assign in_stall = (state != ST_IDLE);

  // Microsequence: each product passes through the prod register, then into acc, before a step writes it back
  always_comb begin
    cmd = '0;
    if (state == ST_RUN) begin
      case (step)
        5'd0:  cmd = mul_op(A_IAB2, B_INV_SQ3, 1'b1, 1'b0, 1'b0);
        5'd2:  cmd.wr = W_BETA;
        5'd3:  cmd = mul_op(A_IA, B_COS, 1'b1, 1'b0, 1'b0);
        5'd4:  cmd = mul_op(A_BETA, B_SIN, 1'b0, 1'b0, 1'b0);
        5'd5:  cmd = mul_op(A_BETA, B_COS, 1'b1, 1'b0, 1'b0);
        5'd6: begin
          cmd    = mul_op(A_IA, B_SIN, 1'b0, 1'b1, 1'b0);
          cmd.wr = W_ID;
        end
        5'd7:  cmd.wr = W_PREP_D;
        5'd8: begin
          cmd    = mul_op(A_LAST_D, B_KP_D, 1'b1, 1'b0, 1'b1);
          cmd.wr = W_IQ;
        end
        5'd9: begin
          cmd    = mul_op(A_SUM_D, B_KI_D, 1'b0, 1'b0, 1'b0);
          cmd.wr = W_PREP_Q;
        end
        5'd10: cmd = mul_op(A_DIFF_D, B_KD_D, 1'b0, 1'b0, 1'b1);
        5'd11: cmd = mul_op(A_LAST_Q, B_KP_Q, 1'b1, 1'b0, 1'b1);
        5'd12: begin
          cmd    = mul_op(A_SUM_Q, B_KI_Q, 1'b0, 1'b0, 1'b0);
          cmd.wr = W_VD;
        end
        5'd13: cmd = mul_op(A_DIFF_Q, B_KD_Q, 1'b0, 1'b0, 1'b1);
        5'd15: cmd.wr = W_VQ;
        5'd16: cmd = mul_op(A_VD, B_COS, 1'b1, 1'b0, 1'b0);
        5'd17: cmd = mul_op(A_VQ, B_SIN, 1'b0, 1'b1, 1'b0);
        5'd18: cmd = mul_op(A_VD, B_SIN, 1'b1, 1'b0, 1'b0);
        5'd19: begin
          cmd    = mul_op(A_VQ, B_COS, 1'b0, 1'b0, 1'b0);
          cmd.wr = W_VALPHA;
        end
        5'd21: cmd.wr = W_VBETA;
        5'd22: cmd = mul_op(A_VALPHA, B_HALF, 1'b1, 1'b1, 1'b0);
        5'd23: cmd = mul_op(A_VBETA, B_HALF_SQ3, 1'b0, 1'b0, 1'b0);
        5'd24: cmd = mul_op(A_VALPHA, B_HALF, 1'b1, 1'b1, 1'b0);
        5'd25: begin
          cmd    = mul_op(A_VBETA, B_HALF_SQ3, 1'b0, 1'b1, 1'b0);
          cmd.wr = W_VB;
        end
        5'd26: cmd = mul_op(A_DUTY_A, B_PERIOD, 1'b1, 1'b0, 1'b0);
        5'd27: cmd.wr = W_VC;
        5'd28: begin
          cmd    = mul_op(A_DUTY_B, B_PERIOD, 1'b1, 1'b0, 1'b0);
          cmd.wr = W_CMPA;
        end
        5'd29: cmd = mul_op(A_DUTY_C, B_PERIOD, 1'b1, 1'b0, 1'b0);
        5'd30: cmd.wr = W_CMPB;
        5'd31: cmd.wr = W_CMPC;
        default: ;
      endcase
    end
    cmd.load_in  = in_valid && !in_stall;
    cmd.load_out = (state == ST_FIN) && (!out_valid || !out_stall);
  end

  // State, step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.load_in) begin
            state <= ST_RUN;
            step  <= '0;
          end
        end
        ST_RUN: begin
          step <= step + 5'd1;
          if (step == LAST_STEP) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (cmd.load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_RUN && step == 5'd0))
    else $error("accepted beat did not start the sequence");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && step == LAST_STEP) |=> (state == ST_FIN))
    else $error("sequence did not finish after last step");

  a_valid_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FIN))
    else $error("result raised outside finish state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && out_valid && out_stall) |=> (state == ST_FIN))
    else $error("pending result overwritten");

endmodule

@@ rtl/foc_current_loop_core.sv @@
`timescale 1ns / 1ps
// in_stall is high from an accepted beat until its result is loaded into the output register;
// a single shared 32x17 multiplier runs the 32-step sequence in between.
// A new beat is accepted while the previous result still waits in the output register.
// Reset (rst, synchronous, active high) restores register defaults, clears both
// error sums and last errors, and drops out_valid.
module foc_current_loop_core #(
  parameter int PWM_PERIOD_COUNTS = 4096,
  parameter int SINE_TABLE_BITS   = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  foccl_pkg::in_beat_t              in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output foccl_pkg::out_beat_t             out_data,
  input  logic                             cfg_we,
  input  logic [foccl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [foccl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import foccl_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  foccl_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  foccl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  foccl_dp #(
    .PWM_PERIOD_COUNTS (PWM_PERIOD_COUNTS),
    .SINE_TABLE_BITS   (SINE_TABLE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

@@ tb/foc_current_loop_core_tb.sv @@
`timescale 1ns / 1ps
module foc_current_loop_core_tb;
  import foccl_pkg::*;

  localparam int PERIOD_CNT  = 4096;
  localparam int ANGLE_BITS  = 8;
  localparam int QSTEPS      = 1 << (ANGLE_BITS - 2);
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE      = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  foc_current_loop_core #(
    .PWM_PERIOD_COUNTS(PERIOD_CNT),
    .SINE_TABLE_BITS(ANGLE_BITS)
  ) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Loop model state: index 0 is the d axis, 1 is the q axis
  logic [15:0] kp_m [2];
  logic [15:0] ki_m [2];
  logic [15:0] kd_m [2];
  logic [30:0] acc_lim_m;
  logic [14:0] v_lim_m;
  longint err_sum_m [2];
  longint last_err_m [2];

  out_beat_t pwm_expected_q [$];
  int fail_count = 0;
  int sent_count = 0;
  int seen_count = 0;
  bit idle_on = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;

  int qsine [0:32] = '{
    0, 1608, 3212, 4808, 6393, 7962, 9512, 11039,
    12539, 14010, 15446, 16846, 18204, 19519, 20787, 22005,
    23170, 24279, 25329, 26319, 27245, 28105, 28898, 29621,
    30273, 30852, 31356, 31785, 32137, 32412, 32609, 32728,
    32767
  };

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint quarter_wave(int p);
    int f, i, fr;
    f = p << (15 - ANGLE_BITS);
    i = f >> 8;
    fr = f & 255;
    if (i >= 32) return qsine[32];
    return qsine[i] + (((qsine[i+1] - qsine[i]) * fr + 128) >> 8);
  endfunction

  function automatic longint sine_of(int idx);
    int quad, p;
    idx = idx & ((1 << ANGLE_BITS) - 1);
    quad = idx >> (ANGLE_BITS - 2);
    p = idx & (QSTEPS - 1);
    case (quad)
      0: return quarter_wave(p);
      1: return quarter_wave(QSTEPS - p);
      2: return -quarter_wave(p);
      default: return -quarter_wave(QSTEPS - p);
    endcase
  endfunction

  // One PID update on axis ax; returns the clamped voltage
  function automatic longint pid_axis(int ax, longint tgt, longint meas);
    longint err, lim, acc, total, v, kp, ki, kd;
    kp = kp_m[ax];
    ki = ki_m[ax];
    kd = kd_m[ax];
    lim = acc_lim_m;
    err = tgt - meas;
    acc = clip(err_sum_m[ax] + err, -lim, lim);
    total = kp * err * 256 + ki * acc + kd * (err - last_err_m[ax]) * 256;
    v = rnd_shift(total, 16);
    err_sum_m[ax] = acc;
    last_err_m[ax] = err;
    return clip(v, -longint'(v_lim_m), longint'(v_lim_m));
  endfunction

  function automatic logic [15:0] duty_count(longint v);
    longint duty;
    duty = clip(16384 + v, 1638, 31130);
    return 16'((duty * PERIOD_CNT) >>> 15);
  endfunction

  function automatic out_beat_t predict_pwm(in_beat_t b);
    out_beat_t o;
    longint ia, ib, s, c, beta, id, iq, vd, vq, valpha, vbeta, vb, vc;
    int idx;
    ia = b.phase_a_current;
    ib = b.phase_b_current;
    idx = int'(b.rotor_angle) >> (16 - ANGLE_BITS);
    s = sine_of(idx);
    c = sine_of(idx + QSTEPS);
    beta = clip(rnd_shift((ia + 2 * ib) * 18919, 15), -32768, 32767);
    id = clip(rnd_shift(ia * c + beta * s, 15), -32768, 32767);
    iq = clip(rnd_shift(beta * c - ia * s, 15), -32768, 32767);
    vd = pid_axis(0, b.d_current_target, id);
    vq = pid_axis(1, b.q_current_target, iq);
    valpha = rnd_shift(vd * c - vq * s, 15);
    vbeta = rnd_shift(vd * s + vq * c, 15);
    vb = rnd_shift(-valpha * 16384 + vbeta * 28378, 15);
    vc = rnd_shift(-valpha * 16384 - vbeta * 28378, 15);
    o.compare_a = duty_count(valpha);
    o.compare_b = duty_count(vb);
    o.compare_c = duty_count(vc);
    o.d_current_measured = id[15:0];
    o.q_current_measured = iq[15:0];
    o.d_voltage = vd[15:0];
    o.q_voltage = vq[15:0];
    return o;
  endfunction

  function automatic void model_reset();
    for (int ax = 0; ax < 2; ax++) begin
      kp_m[ax] = 16'd256;
      ki_m[ax] = '0;
      kd_m[ax] = '0;
      err_sum_m[ax] = 0;
      last_err_m[ax] = 0;
    end
    acc_lim_m = 31'h7FFF_FFFF;
    v_lim_m = 15'h7FFF;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_D_PROP:  kp_m[0] = val[15:0];
      REG_D_INTEG: ki_m[0] = val[15:0];
      REG_D_DERIV: kd_m[0] = val[15:0];
      REG_Q_PROP:  kp_m[1] = val[15:0];
      REG_Q_INTEG: ki_m[1] = val[15:0];
      REG_Q_DERIV: kd_m[1] = val[15:0];
      REG_ACC_LIM: acc_lim_m = val[30:0];
      REG_V_LIM:   v_lim_m = val[14:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_gains(int kpd, int kid, int kdd, int kpq, int kiq, int kdq,
                            int acc, int vl);
    write_reg(REG_D_PROP, CFG_DATA_W'(kpd));
    write_reg(REG_D_INTEG, CFG_DATA_W'(kid));
    write_reg(REG_D_DERIV, CFG_DATA_W'(kdd));
    write_reg(REG_Q_PROP, CFG_DATA_W'(kpq));
    write_reg(REG_Q_INTEG, CFG_DATA_W'(kiq));
    write_reg(REG_Q_DERIV, CFG_DATA_W'(kdq));
    write_reg(REG_ACC_LIM, CFG_DATA_W'(acc));
    write_reg(REG_V_LIM, CFG_DATA_W'(vl));
  endtask

  // Send one sample beat; valid stays high into the next beat when there is no gap
  task automatic send_sample(in_beat_t b);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    pwm_expected_q.push_back(predict_pwm(b));
    sent_count++;
  endtask

  // Wait until every expected beat has come, then let the block settle
  task automatic drain();
    @(posedge clk);
    in_valid <= 1'b0;
    while (pwm_expected_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($signed($urandom_range(0, 2000)) - 1000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_beat_t rand_sample(bit near);
    in_beat_t b;
    b.rotor_angle = 16'($urandom);
    if (near) begin
      // small currents near the targets keep the loops out of saturation
      b.phase_a_current = 16'($signed($urandom_range(0, 4000)) - 2000);
      b.phase_b_current = 16'($signed($urandom_range(0, 4000)) - 2000);
      b.d_current_target = 16'($signed($urandom_range(0, 4000)) - 2000);
      b.q_current_target = 16'($signed($urandom_range(0, 4000)) - 2000);
    end else begin
      b.phase_a_current = pick16();
      b.phase_b_current = pick16();
      b.d_current_target = pick16();
      b.q_current_target = pick16();
    end
    return b;
  endfunction

  task automatic run_random(int count);
    for (int n = 0; n < count; n++) send_sample(rand_sample($urandom_range(0, 2) != 0));
  endtask

  task automatic test_directed();
    in_beat_t b;
    logic [15:0] ext [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    for (int k = 0; k < 8; k++) begin
      b.phase_a_current = ext[k % 4];
      b.phase_b_current = ext[(k / 2) % 4];
      b.rotor_angle = 16'(k * 16'h2000);
      b.d_current_target = ext[(k + 1) % 4];
      b.q_current_target = ext[(k + 3) % 4];
      send_sample(b);
    end
    // angle corners: quadrant edges, odd table steps and full-scale angle
    foreach (ext[k]) begin
      b.phase_a_current = 16'sd12000;
      b.phase_b_current = -16'sd7000;
      b.rotor_angle = (k == 0) ? 16'hFFFF : (k == 1) ? 16'h3F00 : (k == 2) ? 16'h4100 : 16'h00FF;
      b.d_current_target = 16'sd0;
      b.q_current_target = 16'sd5000;
      send_sample(b);
    end
    drain();
  endtask

  task automatic test_gain_corners();
    // maximum gains with wide data; upper bits must be dropped
    load_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    run_random(150);
    drain();
    // zero accumulator and voltage limits: sums pinned, duties at one half
    load_gains(256, 65535, 300, 256, 65535, 300, 0, 0);
    run_random(150);
    drain();
    // all gains zero
    load_gains(0, 0, 0, 0, 0, 0, 1, 1);
    run_random(150);
    drain();
    // integral-heavy, narrow accumulator limit
    load_gains(64, 20000, 0, 64, 20000, 0, 50000, 20000);
    run_random(150);
    drain();
  endtask

  task automatic test_random_settings(int phases);
    int acc;
    for (int ph = 0; ph < phases; ph++) begin
      idle_on = (ph % 3) != 2;
      case ($urandom_range(0, 3))
        0: acc = 0;
        1: acc = $urandom_range(0, 100000);
        2: acc = 32'h7FFF_FFFF;
        default: acc = $urandom & 32'h7FFF_FFFF;
      endcase
      load_gains($urandom_range(0, 1024), $urandom_range(0, 65535), $urandom_range(0, 512),
                 $urandom, $urandom_range(0, 65535), $urandom_range(0, 512),
                 acc, $urandom_range(0, 32767));
      run_random(150);
      drain();
    end
    idle_on = 1'b1;
  endtask

  // Receiver side: random stall per beat while idle_on is set, and the result check
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_count++;
      if (pwm_expected_q.size() == 0) begin
        $error("unexpected output beat");
        fail_count++;
      end else begin
        out_beat_t e;
        e = pwm_expected_q.pop_front();
        if (out_data.compare_a !== e.compare_a) begin
          $error("compare_a exp %0d got %0d", e.compare_a, out_data.compare_a);
          fail_count++;
        end
        if (out_data.compare_b !== e.compare_b) begin
          $error("compare_b exp %0d got %0d", e.compare_b, out_data.compare_b);
          fail_count++;
        end
        if (out_data.compare_c !== e.compare_c) begin
          $error("compare_c exp %0d got %0d", e.compare_c, out_data.compare_c);
          fail_count++;
        end
        if (out_data.d_current_measured !== e.d_current_measured) begin
          $error("d_current_measured exp %0d got %0d", e.d_current_measured,
                 out_data.d_current_measured);
          fail_count++;
        end
        if (out_data.q_current_measured !== e.q_current_measured) begin
          $error("q_current_measured exp %0d got %0d", e.q_current_measured,
                 out_data.q_current_measured);
          fail_count++;
        end
        if (out_data.d_voltage !== e.d_voltage) begin
          $error("d_voltage exp %0d got %0d", e.d_voltage, out_data.d_voltage);
          fail_count++;
        end
        if (out_data.q_voltage !== e.q_voltage) begin
          $error("q_voltage exp %0d got %0d", e.q_voltage, out_data.q_voltage);
          fail_count++;
        end
      end
      stall_left = idle_on ? $urandom_range(0, 9) : 0;
      out_stall <= (stall_left != 0);
    end else if (stall_left > 1) begin
      stall_left--;
    end else if (stall_left == 1) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles without any beat moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    model_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (SETTLE) @(posedge clk);
    test_directed();
    test_gain_corners();
    test_random_settings(9);
    drain();
    if (pwm_expected_q.size() != 0) begin
      $error("%0d expected beats never arrived", pwm_expected_q.size());
      fail_count++;
    end
    $display("Sent %0d samples, checked %0d PWM beats", sent_count, seen_count);
    $display("Covered gain and limit corners, zero limits and random settings");
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ files.f @@
rtl/foccl_pkg.sv
rtl/foccl_regs.sv
rtl/foccl_dp.sv
rtl/foccl_ctrl.sv
rtl/foc_current_loop_core.sv
tb/foc_current_loop_core_tb.sv
